// ===== src/spfb_pkg.sv =====
// ----------------------------------------------------------------------------
// spfb_pkg
// Shared types and codes for the step position follower with backlash
// take-up: request actions, motion codes, register indexes and state records.
// ----------------------------------------------------------------------------
`default_nettype none

package spfb_pkg;

   // Request actions.
   typedef enum logic [3:0] {
      ACT_TICK         = 4'd0,
      ACT_RESET_POS    = 4'd1,
      ACT_SET_TARGET   = 4'd2,
      ACT_SET_INSTR    = 4'd3,
      ACT_MARK_ORIGIN  = 4'd4,
      ACT_TARGET_MOTOR = 4'd5,
      ACT_SET_RATE     = 4'd6,
      ACT_BL_DISABLE   = 4'd7,
      ACT_BL_ENABLE    = 4'd8
   } action_type;

   // Motion codes reported per request.
   localparam logic [1:0] MOVE_NONE = 2'd0;
   localparam logic [1:0] MOVE_FWD  = 2'd1;
   localparam logic [1:0] MOVE_REV  = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_TRACK_ENABLE    = 1'b0;
   localparam logic [0:0] CSR_BACKLASH_AMOUNT = 1'b1;

   localparam int unsigned POS_W = 32;
   localparam int unsigned BL_W  = 16;

   // Configuration registers.
   typedef struct packed {
      logic            track_enable;
      logic [BL_W-1:0] backlash_amount;
   } cfg_type;

   // Axis state.
   typedef struct packed {
      logic [POS_W-1:0] motor_position;
      logic [POS_W-1:0] target_position;
      logic [POS_W-1:0] index_offset;
      logic [POS_W-1:0] origin_position;
      logic [BL_W-1:0]  backlash_position;
      logic [BL_W-1:0]  saved_backlash;
      logic             taking_backlash;
      logic [1:0]       rate_step;
   } axis_state_type;

   // Motion made by one request.
   typedef struct packed {
      logic [1:0] move_dir;
      logic       backlash_step;
   } step_type;

endpackage : spfb_pkg

`default_nettype wire

// ===== src/spfb_axis.sv =====
// ----------------------------------------------------------------------------
// spfb_axis
// Axis state registers and the update for one request: commands rewrite the
// state; a tick may advance the target and makes at most one step.
// ----------------------------------------------------------------------------
`default_nettype none

module spfb_axis
   import spfb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [3:0]       action,
   input  wire logic [POS_W-1:0] value,
   input  wire cfg_type          cfg,
   output axis_state_type        state_next,
   output step_type              step
);

   axis_state_type   state_ff;
   axis_state_type   state_in;
   logic [POS_W-1:0] target_tick;

   // Target after the tracking advance of a tick.
   always_comb begin
      target_tick = state_ff.target_position;
      if (cfg.track_enable && !state_ff.taking_backlash) begin
         target_tick = state_ff.target_position +
                       {{(POS_W-2){state_ff.rate_step[1]}}, state_ff.rate_step};
      end
   end

   // Next state and motion for the current request.
   always_comb begin
      state_in = state_ff;
      step     = '0;
      case (action)
         ACT_TICK: begin
            state_in.target_position = target_tick;
            if ($signed(state_ff.motor_position) > $signed(target_tick)) begin
               step.move_dir = MOVE_REV;
               if (state_ff.backlash_position != '0) begin
                  state_in.taking_backlash   = 1'b1;
                  state_in.backlash_position = state_ff.backlash_position - 1'b1;
                  step.backlash_step         = 1'b1;
               end else begin
                  state_in.taking_backlash = 1'b0;
                  state_in.motor_position  = state_ff.motor_position - 1'b1;
               end
            end else if (($signed(target_tick) > $signed(state_ff.motor_position)) ||
                         state_ff.taking_backlash) begin
               step.move_dir = MOVE_FWD;
               if (state_ff.backlash_position < cfg.backlash_amount) begin
                  state_in.taking_backlash   = 1'b1;
                  state_in.backlash_position = state_ff.backlash_position + 1'b1;
                  step.backlash_step         = 1'b1;
               end else begin
                  state_in.taking_backlash = 1'b0;
                  state_in.motor_position  = state_ff.motor_position + 1'b1;
               end
            end
         end
         ACT_RESET_POS: begin
            state_in.index_offset      = '0;
            state_in.motor_position    = value;
            state_in.target_position   = value;
            state_in.backlash_position = '0;
         end
         ACT_SET_TARGET: begin
            state_in.target_position = value - state_ff.index_offset;
         end
         ACT_SET_INSTR: begin
            state_in.index_offset = value - state_ff.motor_position;
         end
         ACT_MARK_ORIGIN: begin
            state_in.origin_position = state_ff.motor_position;
         end
         ACT_TARGET_MOTOR: begin
            state_in.target_position = state_ff.motor_position;
         end
         ACT_SET_RATE: begin
            if (value == '0) begin
               state_in.rate_step = 2'b00;
            end else if (value[POS_W-1]) begin
               state_in.rate_step = 2'b11;
            end else begin
               state_in.rate_step = 2'b01;
            end
         end
         ACT_BL_DISABLE: begin
            state_in.motor_position    = state_ff.motor_position +
                                         {{(POS_W-BL_W){1'b0}}, state_ff.backlash_position};
            state_in.saved_backlash    = state_ff.backlash_position;
            state_in.backlash_position = '0;
         end
         ACT_BL_ENABLE: begin
            state_in.backlash_position = state_ff.saved_backlash;
            state_in.motor_position    = state_ff.motor_position -
                                         {{(POS_W-BL_W){1'b0}}, state_ff.saved_backlash};
            state_in.saved_backlash    = '0;
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // State registers advance once per processed request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule : spfb_axis

`default_nettype wire

// ===== src/step_position_follower_backlash.sv =====
// ----------------------------------------------------------------------------
// step_position_follower_backlash
// Position follower for one stepper axis with backlash take-up.
//
// A request carries an action and a value; it is accepted at a clock edge
// where req_valid is high and req_stall is low. Each request yields exactly
// one response on the rsp_ channel, accepted where rsp_valid is high and
// rsp_stall is low. An accepted request is held in the input register; when
// the response register can take data, the axis state is updated and the
// response is registered at the same edge. One request per cycle is
// sustained while rsp_stall is low; the state update and the distance
// arithmetic fit in the single stage between the input register and the
// response register.
// The csr_ port writes track_enable (index 0) and backlash_amount (index 1)
// at any edge where csr_write is high; write them only while idle.
// Synchronous reset clears all axis state, the configuration registers
// and both valid flags. While rsp_stall holds a response, the input register
// keeps one more request and req_stall rises once that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module step_position_follower_backlash
   import spfb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_action,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_move_dir,
   output logic                    rsp_backlash_step,
   output logic                    rsp_in_backlash,
   output logic signed [31:0]      rsp_motor_position,
   output logic signed [31:0]      rsp_instrument_coordinate,
   output logic signed [31:0]      rsp_target_coordinate,
   output logic signed [31:0]      rsp_target_distance,
   output logic [30:0]             rsp_nearer_distance,
   output logic signed [1:0]       rsp_rate_direction,
   input  wire logic               csr_write,
   input  wire logic [0:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   cfg_type          cfg_ff;
   logic             in_valid_ff;
   logic             in_valid_in;
   logic [3:0]       in_action_ff;
   logic [POS_W-1:0] in_value_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             advance;
   logic             accept;
   logic             fire;

   axis_state_type   state_next;
   step_type         step;

   logic [POS_W-1:0] dist_origin;
   logic [POS_W-1:0] dist_target;
   logic [POS_W-1:0] abs_origin;
   logic [POS_W-1:0] abs_target;
   logic [POS_W-1:0] nearer;

   logic [1:0]       move_dir_ff;
   logic             backlash_step_ff;
   logic             in_backlash_ff;
   logic [POS_W-1:0] motor_pos_ff;
   logic [POS_W-1:0] instr_coord_ff;
   logic [POS_W-1:0] target_coord_ff;
   logic [POS_W-1:0] target_dist_ff;
   logic [30:0]      nearer_dist_ff;
   logic [1:0]       rate_dir_ff;
   logic [POS_W-1:0] motor_pos_in;
   logic [POS_W-1:0] instr_coord_in;
   logic [POS_W-1:0] target_coord_in;
   logic [30:0]      nearer_dist_in;

   // Handshake: the pipeline moves when the response register can take data.
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign fire         = in_valid_ff && advance;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TRACK_ENABLE:    cfg_ff.track_enable    <= csr_wdata[0];
            CSR_BACKLASH_AMOUNT: cfg_ff.backlash_amount <= csr_wdata;
            default:             cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_value_ff  <= req_value;
      end
   end

   // Axis state and its update.
   spfb_axis u_axis (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .action     (in_action_ff),
      .value      (in_value_ff),
      .cfg        (cfg_ff),
      .state_next (state_next),
      .step       (step)
   );

   // Reported positions and distances from the updated state.
   always_comb begin
      motor_pos_in    = state_next.motor_position +
                        {{(POS_W-BL_W){1'b0}}, state_next.backlash_position};
      instr_coord_in  = state_next.motor_position + state_next.index_offset;
      target_coord_in = state_next.target_position + state_next.index_offset;
      dist_origin     = state_next.origin_position - state_next.motor_position;
      dist_target     = state_next.target_position - state_next.motor_position;
      abs_origin      = dist_origin[POS_W-1] ? (~dist_origin + 1'b1) : dist_origin;
      abs_target      = dist_target[POS_W-1] ? (~dist_target + 1'b1) : dist_target;
      nearer          = (abs_origin < abs_target) ? abs_origin : abs_target;
      // The absolute value of the most negative difference saturates.
      nearer_dist_in  = nearer[POS_W-1] ? {31{1'b1}} : nearer[30:0];
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         move_dir_ff      <= step.move_dir;
         backlash_step_ff <= step.backlash_step;
         in_backlash_ff   <= state_next.taking_backlash;
         motor_pos_ff     <= motor_pos_in;
         instr_coord_ff   <= instr_coord_in;
         target_coord_ff  <= target_coord_in;
         target_dist_ff   <= dist_target;
         nearer_dist_ff   <= nearer_dist_in;
         rate_dir_ff      <= state_next.rate_step;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_move_dir              = move_dir_ff;
   assign rsp_backlash_step         = backlash_step_ff;
   assign rsp_in_backlash           = in_backlash_ff;
   assign rsp_motor_position        = $signed(motor_pos_ff);
   assign rsp_instrument_coordinate = $signed(instr_coord_ff);
   assign rsp_target_coordinate     = $signed(target_coord_ff);
   assign rsp_target_distance       = $signed(target_dist_ff);
   assign rsp_nearer_distance       = nearer_dist_ff;
   assign rsp_rate_direction        = $signed(rate_dir_ff);

endmodule : step_position_follower_backlash

`default_nettype wire

// ===== src/spfb_checker.sv =====
// ----------------------------------------------------------------------------
// spfb_checker
// Port-level checks for the step position follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spfb_checker
   import spfb_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic [3:0]         req_action,
   input wire logic signed [31:0] req_value,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_move_dir,
   input wire logic               rsp_backlash_step,
   input wire logic               rsp_in_backlash,
   input wire logic signed [31:0] rsp_motor_position,
   input wire logic signed [31:0] rsp_instrument_coordinate,
   input wire logic signed [31:0] rsp_target_coordinate,
   input wire logic signed [31:0] rsp_target_distance,
   input wire logic [30:0]        rsp_nearer_distance,
   input wire logic signed [1:0]  rsp_rate_direction,
   input wire logic               csr_write,
   input wire logic [0:0]         csr_index,
   input wire logic [15:0]        csr_wdata
);

   // A stalled response keeps its valid and its motor position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_motor_position))
      else $error("stalled response changed");

   // No response appears in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A backlash step is a motion and leaves the take-up in progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_backlash_step |-> rsp_in_backlash && (rsp_move_dir != MOVE_NONE))
      else $error("backlash step without take-up or motion");

   // Motion code and rate direction never take their unused codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_dir != 2'd3) && (rsp_rate_direction != 2'sb10))
      else $error("unused motion or rate code");

   // With the response side open, the request side is never stalled.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is open");

endmodule : spfb_checker

bind step_position_follower_backlash spfb_checker u_spfb_checker (.*);

`default_nettype wire
